[design/krt_pkg.sv]
// ----------------------------------------------------------------------------
// Keyed record table package
// Shared opcodes, field widths and record types of the keyed record table.
// ----------------------------------------------------------------------------
package krt_pkg;

    localparam int OPCODE_W = 3;
    localparam int MAC_W    = 48;
    localparam int HANDLE_W = 6;
    localparam int CURSOR_W = 6;

    localparam logic [OPCODE_W-1:0] OP_WRITE = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_ERASE = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_FIND  = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_FIRST = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_NEXT  = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_CLEAR = 3'd5;

    typedef struct packed {
        logic        [MAC_W-1:0] mac;
        logic        [7:0]       batt;
        logic signed [7:0]       rssi;
        logic signed [15:0]      temp;
        logic        [31:0]      sent_stamp;
        logic        [15:0]      count;
        logic        [7:0]       rec_type;
    } t_rec;

    typedef struct packed {
        logic                ok;
        logic [HANDLE_W-1:0] handle;
        t_rec                rec;
    } t_result;

endpackage

[design/krt_in_if.sv]
// ----------------------------------------------------------------------------
// Keyed record table request channel
// Valid/ready channel that carries one request item.
// ----------------------------------------------------------------------------
interface krt_in_if
    import krt_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [MAC_W-1:0]    mac;
    logic [7:0]          batt;
    logic signed [7:0]   rssi;
    logic signed [15:0]  temp;
    logic [31:0]         sent_stamp;
    logic [15:0]         count;
    logic [7:0]          rec_type;
    logic [CURSOR_W-1:0] cursor;

    modport source (
        output valid, opcode, mac, batt, rssi, temp, sent_stamp, count, rec_type, cursor,
        input  ready
    );

    modport sink (
        input  valid, opcode, mac, batt, rssi, temp, sent_stamp, count, rec_type, cursor,
        output ready
    );
endinterface

[design/krt_out_if.sv]
// ----------------------------------------------------------------------------
// Keyed record table result channel
// Valid/ready channel that carries one result item.
// ----------------------------------------------------------------------------
interface krt_out_if
    import krt_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                ok;
    logic [HANDLE_W-1:0] handle;
    logic [MAC_W-1:0]    mac_out;
    logic [7:0]          batt_out;
    logic signed [7:0]   rssi_out;
    logic signed [15:0]  temp_out;
    logic [31:0]         sent_stamp_out;
    logic [15:0]         count_out;
    logic [7:0]          type_out;

    modport source (
        output valid, ok, handle, mac_out, batt_out, rssi_out, temp_out, sent_stamp_out,
               count_out, type_out,
        input  ready
    );

    modport sink (
        input  valid, ok, handle, mac_out, batt_out, rssi_out, temp_out, sent_stamp_out,
               count_out, type_out,
        output ready
    );
endinterface

[design/krt_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module krt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[design/keyed_record_table_with_free_list_top.sv]
// ----------------------------------------------------------------------------
// Keyed record table with free list
// Record pool kept as a valid list and a free list, walked by one sequencer.
// ----------------------------------------------------------------------------
// Find and erase walk the valid list one record per cycle through the link
// RAM read port. One item is in flight at a time.
// Reset empties both lists with no clearing pass over the RAMs: a fill count
// marks the slots never taken.
module keyed_record_table_with_free_list_top
    import krt_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    krt_in_if.sink    i_in,
    krt_out_if.source o_out
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW = AW + 1;
    localparam int CW = (LW > CURSOR_W) ? LW : CURSOR_W;
    localparam logic [LW-1:0] NIL = LW'(DEPTH);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_WRITE = 3'd1;
    localparam logic [2:0] ST_WALK  = 3'd2;
    localparam logic [2:0] ST_ERASE = 3'd3;
    localparam logic [2:0] ST_NEXT  = 3'd4;
    localparam logic [2:0] ST_READ  = 3'd5;
    localparam logic [2:0] ST_EMIT  = 3'd6;

    typedef struct packed {
        logic          used;
        logic [LW-1:0] nxt;
    } t_link;

    logic [2:0]          r_state, n_state;
    logic [LW-1:0]       r_vhead, n_vhead;
    logic [LW-1:0]       r_fhead, n_fhead;
    logic [LW-1:0]       r_fill, n_fill;
    logic [OPCODE_W-1:0] r_op, n_op;
    logic                r_from_free, n_from_free;
    logic [AW-1:0]       r_slot, n_slot;
    logic [LW-1:0]       r_prev, n_prev;
    t_rec                r_req, n_req;
    t_result             r_res, n_res;
    logic                r_ov, n_ov;
    t_result             r_out, n_out;

    logic          pay_we;
    logic [AW-1:0] pay_waddr;
    logic          lnk_we;
    logic [AW-1:0] lnk_waddr;
    t_link         lnk_wdata;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    t_rec          rd_pay;
    t_link         rd_lnk;
    logic          accept;

    krt_ram #(.WIDTH($bits(t_rec)), .DEPTH(DEPTH)) u_pay_ram (
        .i_clk   (i_clk),
        .i_we    (pay_we),
        .i_waddr (pay_waddr),
        .i_wdata (r_req),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_pay)
    );

    krt_ram #(.WIDTH($bits(t_link)), .DEPTH(DEPTH)) u_lnk_ram (
        .i_clk   (i_clk),
        .i_we    (lnk_we),
        .i_waddr (lnk_waddr),
        .i_wdata (lnk_wdata),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_lnk)
    );

    assign i_in.ready = (r_state == ST_IDLE);
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        n_state     = r_state;
        n_vhead     = r_vhead;
        n_fhead     = r_fhead;
        n_fill      = r_fill;
        n_op        = r_op;
        n_from_free = r_from_free;
        n_slot      = r_slot;
        n_prev      = r_prev;
        n_req       = r_req;
        n_res       = r_res;
        n_ov        = r_ov;
        n_out       = r_out;
        pay_we      = 1'b0;
        pay_waddr   = r_slot;
        lnk_we      = 1'b0;
        lnk_waddr   = r_slot;
        lnk_wdata   = '0;
        rd_en       = 1'b0;
        rd_addr     = r_slot;

        if (r_ov && o_out.ready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_op             = i_in.opcode;
                    n_req.mac        = i_in.mac;
                    n_req.batt       = i_in.batt;
                    n_req.rssi       = i_in.rssi;
                    n_req.temp       = i_in.temp;
                    n_req.sent_stamp = i_in.sent_stamp;
                    n_req.count      = i_in.count;
                    n_req.rec_type   = i_in.rec_type;
                    n_res            = '0;
                    n_state          = ST_EMIT;
                    case (i_in.opcode)
                        OP_WRITE: begin
                            if (r_fhead != NIL) begin
                                rd_en       = 1'b1;
                                rd_addr     = r_fhead[AW-1:0];
                                n_slot      = r_fhead[AW-1:0];
                                n_from_free = 1'b1;
                                n_state     = ST_WRITE;
                            end else if (r_fill != NIL) begin
                                n_slot      = r_fill[AW-1:0];
                                n_fill      = r_fill + LW'(1);
                                n_from_free = 1'b0;
                                n_state     = ST_WRITE;
                            end
                        end
                        OP_ERASE, OP_FIND: begin
                            if (r_vhead != NIL) begin
                                rd_en   = 1'b1;
                                rd_addr = r_vhead[AW-1:0];
                                n_slot  = r_vhead[AW-1:0];
                                n_prev  = NIL;
                                n_state = ST_WALK;
                            end
                        end
                        OP_FIRST: begin
                            if (r_vhead != NIL) begin
                                rd_en   = 1'b1;
                                rd_addr = r_vhead[AW-1:0];
                                n_slot  = r_vhead[AW-1:0];
                                n_state = ST_READ;
                            end
                        end
                        OP_NEXT: begin
                            if (CW'(i_in.cursor) < CW'(r_fill)) begin
                                rd_en   = 1'b1;
                                rd_addr = AW'(i_in.cursor);
                                n_state = ST_NEXT;
                            end
                        end
                        OP_CLEAR: begin
                            n_vhead  = NIL;
                            n_fhead  = NIL;
                            n_fill   = '0;
                            n_res.ok = 1'b1;
                        end
                        default: begin
                            n_res = '0;
                        end
                    endcase
                end
            end
            ST_WRITE: begin
                if (r_from_free) begin
                    n_fhead = rd_lnk.nxt;
                end
                pay_we         = 1'b1;
                lnk_we         = 1'b1;
                lnk_wdata.used = 1'b1;
                lnk_wdata.nxt  = r_vhead;
                n_vhead        = LW'(r_slot);
                n_res.ok       = 1'b1;
                n_res.handle   = HANDLE_W'(r_slot);
                n_res.rec      = r_req;
                n_state        = ST_EMIT;
            end
            ST_WALK: begin
                if (rd_pay.mac == r_req.mac) begin
                    n_res.ok     = 1'b1;
                    n_res.handle = HANDLE_W'(r_slot);
                    n_res.rec    = rd_pay;
                    n_state      = ST_EMIT;
                    if (r_op == OP_ERASE) begin
                        n_state = ST_ERASE;
                        if (r_prev == NIL) begin
                            n_vhead = rd_lnk.nxt;
                        end else begin
                            lnk_we         = 1'b1;
                            lnk_waddr      = r_prev[AW-1:0];
                            lnk_wdata.used = 1'b1;
                            lnk_wdata.nxt  = rd_lnk.nxt;
                        end
                    end
                end else if (rd_lnk.nxt == NIL) begin
                    n_state = ST_EMIT;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = rd_lnk.nxt[AW-1:0];
                    n_prev  = LW'(r_slot);
                    n_slot  = rd_lnk.nxt[AW-1:0];
                end
            end
            ST_ERASE: begin
                lnk_we         = 1'b1;
                lnk_wdata.used = 1'b0;
                lnk_wdata.nxt  = r_fhead;
                n_fhead        = LW'(r_slot);
                n_state        = ST_EMIT;
            end
            ST_NEXT: begin
                if (!rd_lnk.used || rd_lnk.nxt == NIL) begin
                    n_state = ST_EMIT;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = rd_lnk.nxt[AW-1:0];
                    n_slot  = rd_lnk.nxt[AW-1:0];
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_res.ok     = 1'b1;
                n_res.handle = HANDLE_W'(r_slot);
                n_res.rec    = rd_pay;
                n_state      = ST_EMIT;
            end
            ST_EMIT: begin
                if (!r_ov || o_out.ready) begin
                    n_out   = r_res;
                    n_ov    = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_vhead <= NIL;
            r_fhead <= NIL;
            r_fill  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_vhead <= n_vhead;
            r_fhead <= n_fhead;
            r_fill  <= n_fill;
            r_ov    <= n_ov;
        end
        r_op        <= n_op;
        r_from_free <= n_from_free;
        r_slot      <= n_slot;
        r_prev      <= n_prev;
        r_req       <= n_req;
        r_res       <= n_res;
        r_out       <= n_out;
    end

    assign o_out.valid          = r_ov;
    assign o_out.ok             = r_out.ok;
    assign o_out.handle         = r_out.handle;
    assign o_out.mac_out        = r_out.rec.mac;
    assign o_out.batt_out       = r_out.rec.batt;
    assign o_out.rssi_out       = r_out.rec.rssi;
    assign o_out.temp_out       = r_out.rec.temp;
    assign o_out.sent_stamp_out = r_out.rec.sent_stamp;
    assign o_out.count_out      = r_out.rec.count;
    assign o_out.type_out       = r_out.rec.rec_type;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= NIL)
        else $error("fill count beyond pool depth");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.opcode == OP_CLEAR)
            |=> (r_vhead == NIL && r_fhead == NIL && r_fill == '0))
        else $error("clear left a list non-empty");

    a_fhead_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fhead != NIL) |-> (r_fhead < r_fill))
        else $error("free list head names a slot never taken");

    a_vhead_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vhead != NIL) |-> (r_vhead < r_fill))
        else $error("valid list head names a slot never taken");

    a_walk_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> (LW'(r_slot) < r_fill))
        else $error("list walk reached a slot never taken");
endmodule

[tb/sv/krt_result_checker.sv]
// ----------------------------------------------------------------------------
// Keyed record table result checker
// Watches the request and result channels and keeps its own copy of the slot
// pool, the link array and both list heads. Each accepted request item is
// applied to that copy to form the expected result. Each accepted result item
// is compared field by field with the oldest expected one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module krt_result_checker
    import krt_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    krt_in_if    i_req,
    krt_out_if   i_rsp,
    output int   o_fail_count,
    output int   o_pending
);

    localparam int                LINK_W = $clog2(DEPTH + 1);
    localparam logic [LINK_W-1:0] NIL    = LINK_W'(DEPTH);

    t_rec              rec_mem  [DEPTH];
    logic [LINK_W-1:0] link_mem [DEPTH];
    logic              on_valid [DEPTH];
    logic [LINK_W-1:0] vlist_head;
    logic [LINK_W-1:0] free_head;
    t_result           pending_results [$];
    int                n_fail = 0;

    function automatic void relink_pool();
        for (int i = 0; i < DEPTH; i++) begin
            link_mem[i] = LINK_W'(i + 1);
            on_valid[i] = 1'b0;
        end
        vlist_head = NIL;
        free_head  = '0;
    endfunction

    function automatic t_result slot_result(input logic [LINK_W-1:0] s);
        t_result r;
        r.ok     = 1'b1;
        r.handle = HANDLE_W'(s);
        r.rec    = rec_mem[s];
        return r;
    endfunction

    // Newest matching slot, or NIL; prev gets its predecessor (NIL at head).
    function automatic logic [LINK_W-1:0] find_key(input  logic [MAC_W-1:0]  key,
                                                   output logic [LINK_W-1:0] prev);
        logic [LINK_W-1:0] cur;
        logic [LINK_W-1:0] pred;
        int                steps;
        cur   = vlist_head;
        pred  = NIL;
        prev  = NIL;
        steps = 0;
        while (cur < NIL && steps < DEPTH) begin
            if (rec_mem[cur].mac == key) begin
                prev = pred;
                return cur;
            end
            pred = cur;
            cur  = link_mem[cur];
            steps++;
        end
        return NIL;
    endfunction

    function automatic t_result apply_request(input logic [OPCODE_W-1:0] op,
                                              input t_rec                wr,
                                              input logic [CURSOR_W-1:0] cur);
        t_result           r;
        logic [LINK_W-1:0] s;
        logic [LINK_W-1:0] prev;
        r = '0;
        case (op)
            OP_WRITE: begin
                if (free_head < NIL) begin
                    s           = free_head;
                    free_head   = link_mem[s];
                    rec_mem[s]  = wr;
                    link_mem[s] = vlist_head;
                    on_valid[s] = 1'b1;
                    vlist_head  = s;
                    r           = slot_result(s);
                end
            end
            OP_ERASE: begin
                s = find_key(wr.mac, prev);
                if (s < NIL) begin
                    r = slot_result(s);
                    if (prev == NIL) begin
                        vlist_head = link_mem[s];
                    end else begin
                        link_mem[prev] = link_mem[s];
                    end
                    link_mem[s] = free_head;
                    on_valid[s] = 1'b0;
                    free_head   = s;
                end
            end
            OP_FIND: begin
                s = find_key(wr.mac, prev);
                if (s < NIL) begin
                    r = slot_result(s);
                end
            end
            OP_FIRST: begin
                if (vlist_head < NIL) begin
                    r = slot_result(vlist_head);
                end
            end
            OP_NEXT: begin
                if (int'(cur) < DEPTH && on_valid[cur]) begin
                    s = link_mem[cur];
                    if (s < NIL) begin
                        r = slot_result(s);
                    end
                end
            end
            OP_CLEAR: begin
                relink_pool();
                r.ok = 1'b1;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic show_result(input string tag, input t_result r);
        $display("  %s: ok %0b handle %0d mac %h", tag, r.ok, r.handle, r.rec.mac,
                 " batt %0d rssi %0d temp %0d", r.rec.batt, r.rec.rssi, r.rec.temp,
                 " sent %0d count %0d type %0d", r.rec.sent_stamp, r.rec.count,
                 r.rec.rec_type);
    endtask

    always @(posedge i_clk) begin : watch
        t_rec    wr;
        t_result got;
        t_result want;
        logic    bad;
        if (!i_rst_n) begin
            relink_pool();
            pending_results.delete();
        end else begin
            if (i_req.valid && i_req.ready) begin
                wr.mac        = i_req.mac;
                wr.batt       = i_req.batt;
                wr.rssi       = i_req.rssi;
                wr.temp       = i_req.temp;
                wr.sent_stamp = i_req.sent_stamp;
                wr.count      = i_req.count;
                wr.rec_type   = i_req.rec_type;
                pending_results.push_back(apply_request(i_req.opcode, wr, i_req.cursor));
            end
            if (i_rsp.valid && i_rsp.ready) begin
                got.ok             = i_rsp.ok;
                got.handle         = i_rsp.handle;
                got.rec.mac        = i_rsp.mac_out;
                got.rec.batt       = i_rsp.batt_out;
                got.rec.rssi       = i_rsp.rssi_out;
                got.rec.temp       = i_rsp.temp_out;
                got.rec.sent_stamp = i_rsp.sent_stamp_out;
                got.rec.count      = i_rsp.count_out;
                got.rec.rec_type   = i_rsp.type_out;
                if (pending_results.size() == 0) begin
                    n_fail++;
                    if (n_fail <= 10) begin
                        $display("Result item at %0t with none expected.", $realtime);
                        show_result("actual", got);
                    end
                end else begin
                    want = pending_results.pop_front();
                    bad  = (got.ok !== want.ok) || (got.handle !== want.handle) ||
                           (got.rec.mac !== want.rec.mac) ||
                           (got.rec.batt !== want.rec.batt) ||
                           (got.rec.rssi !== want.rec.rssi) ||
                           (got.rec.temp !== want.rec.temp) ||
                           (got.rec.sent_stamp !== want.rec.sent_stamp) ||
                           (got.rec.count !== want.rec.count) ||
                           (got.rec.rec_type !== want.rec.rec_type);
                    if (bad) begin
                        n_fail++;
                        if (n_fail <= 10) begin
                            $display("Result item mismatch at %0t.", $realtime);
                            show_result("expected", want);
                            show_result("actual  ", got);
                        end
                    end
                end
            end
        end
        o_pending    <= pending_results.size();
        o_fail_count <= n_fail;
    end

endmodule

[tb/sv/tb_keyed_record_table_with_free_list_top.sv]
// ----------------------------------------------------------------------------
// Keyed record table testbench
// Drives request items into the record table: a directed opening over an
// empty list, head, middle and tail erase, list walks and reserved
// opcodes, then random segments that fill, drain or mix the pool over a small
// set of keys. Both channel sides idle at random, and the result side holds
// off once for a long stretch so that the table backs up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_keyed_record_table_with_free_list_top;
    import krt_pkg::*;

    localparam int DEPTH        = 64;
    localparam int N_RANDOM     = 1950;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = DEPTH + 8;
    localparam int N_KEYS       = 16;

    localparam logic [OPCODE_W-1:0] OP_RSVD_6 = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_RSVD_7 = 3'd7;

    localparam int MIX_FILL  = 0;
    localparam int MIX_DRAIN = 1;
    localparam int MIX_ANY   = 2;

    typedef struct {
        logic [OPCODE_W-1:0] opcode;
        t_rec                rec;
        logic [CURSOR_W-1:0] cursor;
    } t_req;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                rx_hold     = 1'b0;
    logic [HANDLE_W-1:0] last_handle = '0;
    logic [MAC_W-1:0]    key_pool [N_KEYS];
    int                  fail_count;
    int                  pending;
    int                  n_sent      = 0;
    int                  tx_calm     = 0;
    int                  cycles      = 0;

    krt_in_if  req_ch ();
    krt_out_if rsp_ch ();

    keyed_record_table_with_free_list_top #(
        .DEPTH (DEPTH)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (rsp_ch)
    );

    krt_result_checker #(
        .DEPTH (DEPTH)
    ) u_result_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic [MAC_W-1:0] rand_mac();
        return MAC_W'({$urandom(), $urandom()});
    endfunction

    function automatic t_req rand_req(input logic [OPCODE_W-1:0] op);
        t_req r;
        r.opcode         = op;
        r.rec.mac        = ($urandom_range(0, 6) == 0) ? rand_mac()
                                                       : key_pool[$urandom_range(0, N_KEYS - 1)];
        r.rec.batt       = 8'($urandom());
        r.rec.rssi       = 8'($urandom());
        r.rec.temp       = 16'($urandom());
        r.rec.sent_stamp = $urandom();
        r.rec.count      = 16'($urandom());
        r.rec.rec_type   = 8'($urandom());
        r.cursor         = ($urandom_range(0, 1) == 0) ? last_handle : CURSOR_W'($urandom());
        return r;
    endfunction

    function automatic logic [OPCODE_W-1:0] pick_op(input int mix);
        int w;
        w = $urandom_range(0, 99);
        case (mix)
            MIX_FILL: begin
                if (w < 72)      return OP_WRITE;
                else if (w < 80) return OP_FIND;
                else if (w < 87) return OP_NEXT;
                else if (w < 90) return OP_FIRST;
                else if (w < 96) return OP_ERASE;
                else if (w < 98) return OP_RSVD_6;
                else             return OP_RSVD_7;
            end
            MIX_DRAIN: begin
                if (w < 45)      return OP_ERASE;
                else if (w < 60) return OP_FIND;
                else if (w < 72) return OP_WRITE;
                else if (w < 90) return OP_NEXT;
                else             return OP_FIRST;
            end
            default: begin
                if (w < 30)      return OP_WRITE;
                else if (w < 50) return OP_ERASE;
                else if (w < 68) return OP_FIND;
                else if (w < 76) return OP_FIRST;
                else if (w < 94) return OP_NEXT;
                else if (w < 96) return OP_CLEAR;
                else if (w < 98) return OP_RSVD_6;
                else             return OP_RSVD_7;
            end
        endcase
    endfunction

    task automatic put(input t_req r);
        int gap;
        if (tx_calm > 0) begin
            tx_calm--;
            gap = 0;
        end else begin
            gap = $urandom_range(0, 3);
            if ($urandom_range(0, 19) == 0) begin
                tx_calm = $urandom_range(10, 40);
            end
        end
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.opcode     <= r.opcode;
        req_ch.mac        <= r.rec.mac;
        req_ch.batt       <= r.rec.batt;
        req_ch.rssi       <= r.rec.rssi;
        req_ch.temp       <= r.rec.temp;
        req_ch.sent_stamp <= r.rec.sent_stamp;
        req_ch.count      <= r.rec.count;
        req_ch.rec_type   <= r.rec.rec_type;
        req_ch.cursor     <= r.cursor;
        req_ch.valid      <= 1'b1;
        do @(posedge i_clk); while (!req_ch.ready);
        n_sent++;
    endtask

    initial begin : result_side
        int rx_wait;
        int rx_calm;
        int gap;
        rx_wait = 0;
        rx_calm = 0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n) begin
                if (rsp_ch.ready && rsp_ch.valid) begin
                    if (rsp_ch.ok) begin
                        last_handle <= rsp_ch.handle;
                    end
                    if (rx_calm > 0) begin
                        rx_calm--;
                    end else if ($urandom_range(0, 15) == 0) begin
                        rx_calm = $urandom_range(8, 40);
                    end
                    gap = (rx_calm > 0) ? 0 : $urandom_range(0, 3);
                    if (rx_hold || gap > 0) begin
                        rsp_ch.ready <= 1'b0;
                        rx_wait = (gap > 0) ? gap - 1 : 0;
                    end
                end else if (!rsp_ch.ready) begin
                    if (rx_wait > 0) begin
                        rx_wait--;
                    end else if (!rx_hold) begin
                        rsp_ch.ready <= 1'b1;
                    end
                end else if (rx_hold) begin
                    rsp_ch.ready <= 1'b0;
                end
            end
        end
    end

    // One long stall on the result side while request items keep coming.
    initial begin
        wait (n_sent >= 300);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    initial begin : stimulus
        t_req r;
        int   mix;
        int   seg_len;
        int   n_rand;
        req_ch.valid      <= 1'b0;
        req_ch.opcode     <= OP_FIRST;
        req_ch.mac        <= '0;
        req_ch.batt       <= '0;
        req_ch.rssi       <= '0;
        req_ch.temp       <= '0;
        req_ch.sent_stamp <= '0;
        req_ch.count      <= '0;
        req_ch.rec_type   <= '0;
        req_ch.cursor     <= '0;
        for (int i = 0; i < N_KEYS; i++) begin
            key_pool[i] = rand_mac();
        end
        key_pool[0] = '0;
        key_pool[1] = '1;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty table: every lookup fails and a free cursor is rejected.
        put(rand_req(OP_CLEAR));
        put(rand_req(OP_FIRST));
        r = rand_req(OP_FIND);
        r.rec.mac = key_pool[2];
        put(r);
        r = rand_req(OP_ERASE);
        r.rec.mac = key_pool[2];
        put(r);
        r = rand_req(OP_NEXT);
        r.cursor = '1;
        put(r);

        // Field extremes, then a duplicate key so the newest copy wins.
        r = rand_req(OP_WRITE);
        r.rec      = '0;
        r.rec.rssi = 8'sh80;
        r.rec.temp = 16'sh8000;
        put(r);
        r = rand_req(OP_WRITE);
        r.rec      = '1;
        r.rec.rssi = 8'sh7f;
        r.rec.temp = 16'sh7fff;
        put(r);
        r = rand_req(OP_WRITE);
        r.rec.mac = key_pool[2];
        put(r);
        r = rand_req(OP_WRITE);
        r.rec.mac = key_pool[2];
        put(r);
        r = rand_req(OP_FIND);
        r.rec.mac = key_pool[2];
        put(r);
        put(rand_req(OP_FIRST));
        r = rand_req(OP_NEXT);
        r.cursor = 6'd3;
        put(r);
        r = rand_req(OP_NEXT);
        r.cursor = 6'd0;
        put(r);

        // Erase at the head and in the middle, then walk from a freed slot.
        r = rand_req(OP_ERASE);
        r.rec.mac = key_pool[2];
        put(r);
        r = rand_req(OP_ERASE);
        r.rec.mac = '1;
        put(r);
        r = rand_req(OP_NEXT);
        r.cursor = 6'd1;
        put(r);
        r = rand_req(OP_FIND);
        r.rec.mac = rand_mac();
        put(r);
        put(rand_req(OP_RSVD_6));
        put(rand_req(OP_RSVD_7));
        put(rand_req(OP_WRITE));

        // The oldest record sits at the tail of the list.
        r = rand_req(OP_FIND);
        r.rec.mac = '0;
        put(r);
        r = rand_req(OP_ERASE);
        r.rec.mac = '0;
        put(r);
        put(rand_req(OP_CLEAR));
        put(rand_req(OP_FIRST));

        n_rand = 0;
        while (n_rand < N_RANDOM) begin
            mix     = $urandom_range(MIX_FILL, MIX_ANY);
            seg_len = $urandom_range(30, 120);
            key_pool[$urandom_range(2, N_KEYS - 1)] = rand_mac();
            if ($urandom_range(0, 3) == 0) begin
                put(rand_req(OP_CLEAR));
                n_rand++;
            end
            for (int k = 0; k < seg_len && n_rand < N_RANDOM; k++) begin
                put(rand_req(pick_op(mix)));
                n_rand++;
            end
        end
        req_ch.valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[files.f]
design/krt_pkg.sv
design/krt_in_if.sv
design/krt_out_if.sv
design/krt_ram.sv
design/keyed_record_table_with_free_list_top.sv
tb/sv/krt_result_checker.sv
tb/sv/tb_keyed_record_table_with_free_list_top.sv
